// File: rtl/sha1ds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1ds_pkg
// Types, constants and helper functions shared by the SHA-1 stream digest.
// ----------------------------------------------------------------------------
package sha1ds_pkg;

   localparam int unsigned WORD_COUNT  = 5;
   localparam int unsigned BLOCK_WORDS = 16;

   localparam logic [6:0] LAST_ROUND     = 7'd79;
   localparam logic [6:0] LAST_LOAD      = 7'd15;
   localparam logic [6:0] FIRST_SCHED    = 7'd16;
   localparam logic [6:0] PHASE_PARITY_A = 7'd20;
   localparam logic [6:0] PHASE_MAJ      = 7'd40;
   localparam logic [6:0] PHASE_PARITY_B = 7'd60;
   localparam logic [2:0] LAST_WORD      = 3'd4;
   localparam logic [5:0] LAST_BYTE_POS  = 6'd63;
   localparam logic [5:0] LEN_BYTE_POS   = 6'd56;
   localparam logic [3:0] LEN_HI_WORD    = 4'd14;
   localparam logic [3:0] LEN_LO_WORD    = 4'd15;
   localparam logic [7:0] PAD_BYTE       = 8'h80;

   localparam logic [31:0] H_INIT [WORD_COUNT] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam logic [31:0] K_CH     = 32'h5A827999;
   localparam logic [31:0] K_PAR_A  = 32'h6ED9EBA1;
   localparam logic [31:0] K_MAJ    = 32'h8F1BBCDC;
   localparam logic [31:0] K_PAR_B  = 32'hCA62C1D6;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       no_data;
      logic       last;
   } req_item_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        final_word;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREFETCH,
      ST_ROUND,
      ST_UPDATE,
      ST_EMIT
   } ctrl_state_type;

   // What the block being compressed holds beyond the buffered bytes.
   typedef enum logic [1:0] {
      BLK_DATA,
      BLK_PAD,
      BLK_PAD_NOLEN,
      BLK_LEN
   } block_kind_type;

   typedef struct packed {
      logic       wr_en;
      logic [3:0] wr_addr;
      logic [1:0] wr_lane;
      logic [7:0] wr_byte;
      logic       rd_en;
      logic [3:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic       init_work;
      logic       round_en;
      logic       load_word;
      logic       add_chain;
      logic       reset_chain;
      logic [6:0] round_idx;
      logic [2:0] word_idx;
   } core_ctrl_type;

   typedef struct packed {
      block_kind_type kind;
      logic [5:0]     pad_pos;
      logic [63:0]    bit_len;
   } pad_info_type;

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // Replaces buffered bytes with the pad byte, zeros and the length field
   // according to the kind of block being compressed.
   function automatic logic [31:0] pad_word(input logic [31:0]    raw,
                                            input logic [3:0]     widx,
                                            input block_kind_type kind,
                                            input logic [5:0]     pos,
                                            input logic [63:0]    bit_len);
      logic [31:0] res;
      logic [5:0]  bidx;
      res = raw;
      case (kind)
         BLK_DATA: begin
            res = raw;
         end
         BLK_PAD, BLK_PAD_NOLEN: begin
            for (int j = 0; j < 4; j++) begin
               bidx = {widx, 2'(j)};
               if (bidx == pos) begin
                  res[(3 - j) * 8 +: 8] = PAD_BYTE;
               end else if (bidx > pos) begin
                  res[(3 - j) * 8 +: 8] = 8'h00;
               end
            end
            if (kind == BLK_PAD && widx == LEN_HI_WORD) begin
               res = bit_len[63:32];
            end else if (kind == BLK_PAD && widx == LEN_LO_WORD) begin
               res = bit_len[31:0];
            end
         end
         BLK_LEN: begin
            if (widx == LEN_HI_WORD) begin
               res = bit_len[63:32];
            end else if (widx == LEN_LO_WORD) begin
               res = bit_len[31:0];
            end else begin
               res = 32'h0;
            end
         end
         default: begin
            res = raw;
         end
      endcase
      return res;
   endfunction

endpackage

// File: rtl/sha1ds_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1ds_buffer
// Block buffer: sixteen big-endian 32-bit words with byte-lane writes and a
// registered read port.
// ----------------------------------------------------------------------------
module sha1ds_buffer (
   input  logic                     clock,
   input  sha1ds_pkg::mem_req_type  mem_req,
   output logic [31:0]              rd_data
);
   import sha1ds_pkg::*;

   logic [31:0] mem_ff [BLOCK_WORDS];
   logic [31:0] rd_data_ff;

   // Byte 0 of a word sits in the most significant lane.
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr][{~mem_req.wr_lane, 3'b000} +: 8] <= mem_req.wr_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/sha1ds_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1ds_core
// SHA-1 round unit: one round per cycle over the working variables, a
// sixteen-word schedule window and the five-word chaining value.
// ----------------------------------------------------------------------------
module sha1ds_core (
   input  logic                      clock,
   input  logic                      reset,
   input  sha1ds_pkg::core_ctrl_type ctrl,
   input  logic [31:0]               sched_word,
   output logic [31:0]               digest_word
);
   import sha1ds_pkg::*;

   logic [31:0] chain_ff [WORD_COUNT];
   logic [31:0] win_ff [BLOCK_WORDS];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] w_in;
   logic [31:0] f_val;
   logic [31:0] k_val;
   logic [31:0] t_in;

   // The window holds W[t-16] at index 0 up to W[t-1] at index 15.
   always_comb begin
      if (ctrl.load_word) begin
         w_in = sched_word;
      end else begin
         w_in = rotl32(win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0], 1);
      end
   end

   always_comb begin
      if (ctrl.round_idx < PHASE_PARITY_A) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = K_CH;
      end else if (ctrl.round_idx < PHASE_MAJ) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K_PAR_A;
      end else if (ctrl.round_idx < PHASE_PARITY_B) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = K_MAJ;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K_PAR_B;
      end
      t_in = rotl32(a_ff, 5) + f_val + e_ff + k_val + w_in;
   end

   always_ff @(posedge clock) begin
      if (ctrl.init_work) begin
         a_ff <= chain_ff[0];
         b_ff <= chain_ff[1];
         c_ff <= chain_ff[2];
         d_ff <= chain_ff[3];
         e_ff <= chain_ff[4];
      end else if (ctrl.round_en) begin
         a_ff <= t_in;
         b_ff <= a_ff;
         c_ff <= rotl32(b_ff, 30);
         d_ff <= c_ff;
         e_ff <= d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.round_en) begin
         for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
            win_ff[i] <= win_ff[i + 1];
         end
         win_ff[BLOCK_WORDS - 1] <= w_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.reset_chain) begin
         chain_ff <= H_INIT;
      end else if (ctrl.add_chain) begin
         chain_ff[0] <= chain_ff[0] + a_ff;
         chain_ff[1] <= chain_ff[1] + b_ff;
         chain_ff[2] <= chain_ff[2] + c_ff;
         chain_ff[3] <= chain_ff[3] + d_ff;
         chain_ff[4] <= chain_ff[4] + e_ff;
      end
   end

   always_comb begin
      case (ctrl.word_idx)
         3'd0:    digest_word = chain_ff[0];
         3'd1:    digest_word = chain_ff[1];
         3'd2:    digest_word = chain_ff[2];
         3'd3:    digest_word = chain_ff[3];
         3'd4:    digest_word = chain_ff[4];
         default: digest_word = chain_ff[0];
      endcase
   end

endmodule

// File: rtl/sha1ds_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1ds_ctrl
// Sequencer: takes items, writes bytes into the block buffer, keeps the
// byte count, steps the rounds and hands the digest words out.
// ----------------------------------------------------------------------------
module sha1ds_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  sha1ds_pkg::req_item_type  req_item,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output sha1ds_pkg::mem_req_type   mem_req,
   output sha1ds_pkg::core_ctrl_type core_ctrl,
   output sha1ds_pkg::pad_info_type  pad_info
);
   import sha1ds_pkg::*;

   ctrl_state_type state_ff, state_in;
   block_kind_type kind_ff;
   logic [6:0]     round_ff;
   logic [2:0]     word_idx_ff;
   logic [60:0]    byte_total_ff;
   logic           last_ff;

   logic       accept;
   logic       has_byte;
   logic [5:0] pos;
   logic [5:0] pad_pos_in;
   logic       block_full;
   logic       emit_done;

   assign accept     = req_valid && (state_ff == ST_IDLE);
   assign has_byte   = !req_item.no_data;
   assign pos        = byte_total_ff[5:0];
   assign pad_pos_in = has_byte ? pos + 6'd1 : pos;
   assign block_full = has_byte && (pos == LAST_BYTE_POS);
   assign emit_done  = (state_ff == ST_EMIT) && rsp_ready && (word_idx_ff == LAST_WORD);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (block_full || req_item.last)) begin
               state_in = ST_PREFETCH;
            end
         end
         ST_PREFETCH: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (round_ff == LAST_ROUND) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if ((kind_ff == BLK_DATA && last_ff) || kind_ff == BLK_PAD_NOLEN) begin
               state_in = ST_PREFETCH;
            end else if (kind_ff == BLK_PAD || kind_ff == BLK_LEN) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (emit_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_EMIT);

      mem_req.wr_en   = accept && has_byte;
      mem_req.wr_addr = pos[5:2];
      mem_req.wr_lane = pos[1:0];
      mem_req.wr_byte = req_item.data_byte;
      mem_req.rd_en   = (state_ff == ST_PREFETCH) ||
                        ((state_ff == ST_ROUND) && (round_ff < LAST_LOAD));
      mem_req.rd_addr = (state_ff == ST_PREFETCH) ? 4'd0 : round_ff[3:0] + 4'd1;

      core_ctrl.init_work   = (state_ff == ST_PREFETCH);
      core_ctrl.round_en    = (state_ff == ST_ROUND);
      core_ctrl.load_word   = (round_ff < FIRST_SCHED);
      core_ctrl.add_chain   = (state_ff == ST_UPDATE);
      core_ctrl.reset_chain = emit_done;
      core_ctrl.round_idx   = round_ff;
      core_ctrl.word_idx    = word_idx_ff;

      pad_info.kind    = kind_ff;
      pad_info.pad_pos = pos;
      pad_info.bit_len = {byte_total_ff, 3'b000};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         kind_ff       <= BLK_DATA;
         round_ff      <= '0;
         word_idx_ff   <= '0;
         byte_total_ff <= '0;
         last_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (accept) begin
            last_ff <= req_item.last;
            if (has_byte) begin
               byte_total_ff <= byte_total_ff + 61'd1;
            end
            if (block_full) begin
               kind_ff <= BLK_DATA;
            end else if (pad_pos_in >= LEN_BYTE_POS) begin
               kind_ff <= BLK_PAD_NOLEN;
            end else begin
               kind_ff <= BLK_PAD;
            end
         end

         // A full data block leaves the position at zero, so its pad fits.
         if (state_ff == ST_UPDATE) begin
            if (kind_ff == BLK_DATA) begin
               kind_ff <= BLK_PAD;
            end else if (kind_ff == BLK_PAD_NOLEN) begin
               kind_ff <= BLK_LEN;
            end
         end

         if (state_ff == ST_PREFETCH) begin
            round_ff <= '0;
         end else if (state_ff == ST_ROUND) begin
            round_ff <= round_ff + 7'd1;
         end

         if (state_ff == ST_EMIT && rsp_ready) begin
            word_idx_ff <= (word_idx_ff == LAST_WORD) ? 3'd0 : word_idx_ff + 3'd1;
         end

         if (emit_done) begin
            byte_total_ff <= '0;
            last_ff       <= 1'b0;
         end
      end
   end

endmodule

// File: rtl/sha1_digest_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_digest_stream
// SHA-1 digest of a byte stream: at most one message byte per item, five
// digest words out after the item marked last.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload          Handshake
//  req_     in         req_item_type    req_valid / req_ready
//  rsp_     out        rsp_item_type    rsp_valid / rsp_ready
//
// A byte that does not complete a block is only written into the buffer.
// A byte completing a block starts a compression: prefetch, 80 rounds, update.
// The last item adds one pad block, or two when the pad does not fit, then
// five digest words.
// Reset is synchronous; no clearing pass is needed after it.
// A stall on rsp_ready holds the current digest word and blocks new items.
// ----------------------------------------------------------------------------
module sha1_digest_stream (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  sha1ds_pkg::req_item_type req_item,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output sha1ds_pkg::rsp_item_type rsp_item
);
   import sha1ds_pkg::*;

   mem_req_type   mem_req;
   core_ctrl_type core_ctrl;
   pad_info_type  pad_info;
   logic [31:0]   rd_data;
   logic [31:0]   sched_word;
   logic [31:0]   digest_word;

   sha1ds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .mem_req   (mem_req),
      .core_ctrl (core_ctrl),
      .pad_info  (pad_info)
   );

   sha1ds_buffer u_buffer (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign sched_word = pad_word(rd_data, core_ctrl.round_idx[3:0], pad_info.kind,
                                pad_info.pad_pos, pad_info.bit_len);

   sha1ds_core u_core (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (core_ctrl),
      .sched_word  (sched_word),
      .digest_word (digest_word)
   );

   always_comb begin
      rsp_item.digest_word = digest_word;
      rsp_item.word_index  = core_ctrl.word_idx;
      rsp_item.final_word  = (core_ctrl.word_idx == LAST_WORD);
   end

endmodule

// File: rtl/sha1ds_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1ds_checker
// Port-level checks on the digest stream, bound to the top level.
// ----------------------------------------------------------------------------
module sha1ds_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input sha1ds_pkg::rsp_item_type rsp_item
);
   import sha1ds_pkg::*;

   // A stalled digest word must not move.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("digest word changed while stalled");

   // No new item is taken while a digest is being handed out.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("item accepted during digest output");

   // Words follow in order without gaps.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_item.final_word |=>
         rsp_valid && (rsp_item.word_index == $past(rsp_item.word_index) + 3'd1))
      else $error("digest words out of order");

   // The final flag marks the fifth word only, and nothing follows it at once.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.final_word == (rsp_item.word_index == LAST_WORD)))
      else $error("final flag on the wrong word");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_item.final_word |=> !rsp_valid)
      else $error("word shown after the final digest word");

endmodule

bind sha1_digest_stream sha1ds_checker u_sha1ds_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);

// File: tb/sv/sha1_digest_stream_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_digest_stream_tb
// Streams byte messages into the SHA-1 block and checks every digest word
// against a digest computed inside the bench, under several idle patterns.
// ----------------------------------------------------------------------------
module sha1_digest_stream_tb;

   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hEFCDAB89;
   localparam logic [31:0] IV2 = 32'h98BADCFE;
   localparam logic [31:0] IV3 = 32'h10325476;
   localparam logic [31:0] IV4 = 32'hC3D2E1F0;
   localparam logic [31:0] RC_CH    = 32'h5A827999;
   localparam logic [31:0] RC_PAR_A = 32'h6ED9EBA1;
   localparam logic [31:0] RC_MAJ   = 32'h8F1BBCDC;
   localparam logic [31:0] RC_PAR_B = 32'hCA62C1D6;
   localparam logic [7:0]  PAD_MARK = 8'h80;
   localparam int          DIGEST_WORDS = 5;
   localparam int          MAX_PRINTED  = 40;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   sha1ds_pkg::req_item_type req_item = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   sha1ds_pkg::rsp_item_type rsp_item;

   // Digest state of the bench's own SHA-1.
   logic [31:0] sha_chain [DIGEST_WORDS];
   logic [7:0]  sha_block [64];
   logic [60:0] sha_byte_count;

   sha1ds_pkg::rsp_item_type digest_expect [$];
   sha1ds_pkg::rsp_item_type digest_want;

   int mismatch_count  = 0;
   int byte_items      = 0;
   int ignored_items   = 0;
   int digests_started = 0;
   int words_checked   = 0;
   int req_idle_pct    = 0;
   int rsp_stall_pct   = 0;
   int hold_request    = 0;
   int hold_left       = 0;

   sha1_digest_stream DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void sha1_restart();
      sha_chain[0] = IV0;
      sha_chain[1] = IV1;
      sha_chain[2] = IV2;
      sha_chain[3] = IV3;
      sha_chain[4] = IV4;
      foreach (sha_block[i]) sha_block[i] = 8'h00;
      sha_byte_count = '0;
   endfunction

   function automatic void sha1_compress();
      logic [31:0] sched [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int r = 0; r < 16; r++) begin
         sched[r] = {sha_block[4 * r], sha_block[4 * r + 1],
                     sha_block[4 * r + 2], sha_block[4 * r + 3]};
      end
      for (int r = 16; r < 80; r++) begin
         t = sched[r - 3] ^ sched[r - 8] ^ sched[r - 14] ^ sched[r - 16];
         sched[r] = {t[30:0], t[31]};
      end
      a = sha_chain[0];
      b = sha_chain[1];
      c = sha_chain[2];
      d = sha_chain[3];
      e = sha_chain[4];
      for (int r = 0; r < 80; r++) begin
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = RC_CH;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = RC_PAR_A;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = RC_MAJ;
         end else begin
            f = b ^ c ^ d;
            k = RC_PAR_B;
         end
         t = {a[26:0], a[31:27]} + f + e + k + sched[r];
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = t;
      end
      sha_chain[0] = sha_chain[0] + a;
      sha_chain[1] = sha_chain[1] + b;
      sha_chain[2] = sha_chain[2] + c;
      sha_chain[3] = sha_chain[3] + d;
      sha_chain[4] = sha_chain[4] + e;
   endfunction

   // Takes one accepted item into the digest; an item marked last finishes
   // the message and queues the five digest words it must produce.
   function automatic void sha1_absorb_item(input sha1ds_pkg::req_item_type it);
      logic [5:0]               fill;
      logic [63:0]              bit_length;
      sha1ds_pkg::rsp_item_type word;
      if (!it.no_data) begin
         fill = sha_byte_count[5:0];
         sha_block[fill] = it.data_byte;
         sha_byte_count = sha_byte_count + 61'd1;
         if (fill == 6'd63) sha1_compress();
      end
      if (!it.last) return;
      fill = sha_byte_count[5:0];
      sha_block[fill] = PAD_MARK;
      for (int i = fill + 1; i < 64; i++) sha_block[i] = 8'h00;
      // No room left for the length field: it goes into a block of its own.
      if (fill >= 6'd56) begin
         sha1_compress();
         foreach (sha_block[i]) sha_block[i] = 8'h00;
      end
      bit_length = {sha_byte_count, 3'b000};
      for (int i = 0; i < 8; i++) sha_block[63 - i] = bit_length[8 * i +: 8];
      sha1_compress();
      for (int i = 0; i < DIGEST_WORDS; i++) begin
         word.digest_word = sha_chain[i];
         word.word_index  = 3'(i);
         word.final_word  = (i == DIGEST_WORDS - 1);
         digest_expect.push_back(word);
      end
      digests_started++;
      sha1_restart();
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < MAX_PRINTED) begin
         $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
      end
      mismatch_count++;
   endtask

   // Result checker.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (digest_expect.size() == 0) begin
            report_mismatch("unexpected digest word", rsp_item.digest_word, '0);
         end else begin
            digest_want = digest_expect.pop_front();
            if (rsp_item.digest_word !== digest_want.digest_word) begin
               report_mismatch("digest_word", rsp_item.digest_word, digest_want.digest_word);
            end
            if (rsp_item.word_index !== digest_want.word_index) begin
               report_mismatch("word_index", 32'(rsp_item.word_index),
                               32'(digest_want.word_index));
            end
            if (rsp_item.final_word !== digest_want.final_word) begin
               report_mismatch("final_word", 32'(rsp_item.final_word),
                               32'(digest_want.final_word));
            end
         end
         words_checked++;
      end
   end

   // Result side: random stalls, plus a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_request > 0) begin
         rsp_ready    <= 1'b0;
         hold_left    <= hold_request;
         hold_request <= 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Within a message, valid is only dropped here, so it is never lowered and
   // raised in the same step when items follow back to back.
   task automatic idle_before_item();
      if (req_idle_pct > 0 && $urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
   endtask

   task automatic send_item(input sha1ds_pkg::req_item_type it);
      idle_before_item();
      req_item  <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sha1_absorb_item(it);
      if (!it.no_data) begin
         byte_items++;
      end else if (!it.last) begin
         ignored_items++;
      end
   endtask

   task automatic send_byte(input logic [7:0] value, input logic is_last);
      sha1ds_pkg::req_item_type it;
      it.data_byte = value;
      it.no_data   = 1'b0;
      it.last      = is_last;
      send_item(it);
   endtask

   // An item without a byte; its data field is random and must be ignored.
   task automatic send_empty(input logic is_last);
      sha1ds_pkg::req_item_type it;
      it.data_byte = 8'($urandom_range(255));
      it.no_data   = 1'b1;
      it.last      = is_last;
      send_item(it);
   endtask

   // A message of length random bytes. The end is marked either on the final
   // byte or by a separate empty item; stray empty items may be mixed in.
   task automatic send_message(input int length, input bit separate_tail,
                               input bit with_noise);
      bit tail_item;
      tail_item = separate_tail || (length == 0);
      for (int i = 0; i < length; i++) begin
         if (with_noise && $urandom_range(15) == 0) send_empty(1'b0);
         send_byte(8'($urandom_range(255)), !tail_item && (i == length - 1));
      end
      if (tail_item) send_empty(1'b1);
   endtask

   task automatic wait_for_digests();
      while (digest_expect.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_cases();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      // Empty message.
      send_empty(1'b1);
      // A stray empty item is ignored, then a single zero byte ends the message.
      send_empty(1'b0);
      send_byte(8'h00, 1'b1);
      // "abc", the usual known-answer message.
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b0);
      send_byte(8'h63, 1'b1);
      send_byte(8'hFF, 1'b1);
      // Two bytes followed by an empty tail, with an ignored item between them.
      send_byte(8'hA5, 1'b0);
      send_empty(1'b0);
      send_byte(8'h5A, 1'b0);
      send_empty(1'b1);
      // Two empty messages back to back.
      send_empty(1'b1);
      send_empty(1'b1);
   endtask

   task automatic test_random_messages(input int idle_pct, input int stall_pct,
                                       input int item_goal, input int opening_length);
      int first_item, length;
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      // A long opening message either fills a whole block or ends where the
      // pad needs a second block.
      if (opening_length > 0) begin
         send_message(opening_length, 1'($urandom_range(1)), 1'b0);
      end
      first_item = byte_items;
      while (byte_items - first_item < item_goal) begin
         length = $urandom_range(8);
         send_message(length, 1'($urandom_range(1)), 1'b1);
      end
   endtask

   task automatic test_output_backpressure();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      hold_request <= 600;
      // Several short messages queue up behind the held digest.
      for (int m = 0; m < 4; m++) send_message($urandom_range(6, 1), 1'b0, 1'b0);
      req_valid <= 1'b0;
      wait_for_digests();
      @(posedge clock);
      send_message(3, 1'b1, 1'b0);
   endtask

   initial begin
      sha1_restart();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_random_messages(0, 0, 0, $urandom_range(72, 64));
      test_random_messages(48, 0, 6, 0);
      test_random_messages(0, 48, 6, 0);
      test_random_messages(38, 38, 0, $urandom_range(63, 56));
      test_output_backpressure();
      req_valid <= 1'b0;
      wait_for_digests();
      repeat (100) @(posedge clock);
      $display("Hashed %0d messages from %0d bytes (%0d ignored items), %0d digest words checked.",
               digests_started, byte_items, ignored_items, words_checked);
      $display("Idle patterns: none, sender gaps, result stalls, both, and a long result hold.");
      if (mismatch_count == 0 && digest_expect.size() == 0) begin
         $display("sha1_digest_stream test passed");
      end else begin
         $display("sha1_digest_stream test failed");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Timed out with %0d digest words outstanding.", digest_expect.size());
      $display("sha1_digest_stream test failed");
      $finish;
   end

endmodule
